>>> rtl/core/mdpg_pkg.sv
// Shared types and constants for the point grid insert core.
package mdpg_pkg;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT   = 2'd0,
      VERDICT_OCCUPIED = 2'd1,
      VERDICT_CLOSE    = 2'd2,
      VERDICT_OUTSIDE  = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      REG_MIN_DIST_SQ  = 3'd0,
      REG_INV_CELL_LEN = 3'd1,
      REG_CELLS_X      = 3'd2,
      REG_CELLS_Y      = 3'd3,
      REG_CELLS_Z      = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_CELL,
      ST_CHECK,
      ST_SCAN,
      ST_OWNER,
      ST_POINT,
      ST_DIST,
      ST_SUM,
      ST_WRITE,
      ST_DONE
   } state_type;

   localparam int COORD_BITS = 16;
   localparam int VERDICT_BITS = 2;
   localparam int CELL_OUT_BITS = 15;
   localparam int COUNT_OUT_BITS = 16;
   localparam int CFG_DATA_BITS = 34;
   localparam int CFG_INDEX_BITS = 3;
   localparam int MIN_DIST_BITS = 34;
   localparam int INV_LEN_BITS = 32;
   localparam int NCELL_BITS = 6;

endpackage

>>> rtl/core/mdpg_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
module mdpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/core/min_distance_point_grid_insert_core.sv
// Top level of the minimum-distance point grid insert core.
//
// Usage: a candidate point (req_cand_x/y/z) is taken when req_valid is high and
// req_stall is low. One result transaction (rsp_verdict, rsp_cell_index,
// rsp_point_index, rsp_point_count) follows on the rsp_ channel and is held
// while rsp_stall is high. Registers are written through csr_valid/csr_ready,
// csr_index and csr_data, by the user only while the core is idle, which the
// core itself does not enforce. One candidate is processed at a time. An
// outside candidate or an occupied cell goes straight to the result. Otherwise
// the (2*SEARCH_REACH+1)^3 neighbour offsets are scanned, clipped or not, one
// per cycle through the cell memory's read port while no stored point is being
// checked; every stored point found is checked through the point memory, and
// the scan stops at the first one that is too close. A new candidate is taken
// in the cycle after the result transaction is accepted.
// After reset the core sweeps all MAX_CELLS_PER_AXIS^3 entries (32768 by default)
// of the cell-used memory once, one entry per cycle; req_stall stays high until
// the sweep ends. Configuration writes are accepted throughout. While the
// receiver stalls, the result is held and no new candidate is taken.
module min_distance_point_grid_insert_core #(
   parameter int MAX_CELLS_PER_AXIS = 32,
   parameter int SEARCH_REACH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_cand_x,
   input  logic [15:0]                         req_cand_y,
   input  logic [15:0]                         req_cand_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mdpg_pkg::VERDICT_BITS-1:0]   rsp_verdict,
   output logic [mdpg_pkg::CELL_OUT_BITS-1:0]  rsp_cell_index,
   output logic [mdpg_pkg::CELL_OUT_BITS-1:0]  rsp_point_index,
   output logic [mdpg_pkg::COUNT_OUT_BITS-1:0] rsp_point_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mdpg_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  logic [mdpg_pkg::CFG_DATA_BITS-1:0]  csr_data
);
   import mdpg_pkg::*;

   localparam int AXB = $clog2(MAX_CELLS_PER_AXIS);
   localparam int CAP = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
   localparam int AB = $clog2(CAP);
   localparam int CNTB = AB + 1;
   localparam int CB = COORD_BITS;
   localparam int PRODB = CB + INV_LEN_BITS;
   localparam int OFFB = $clog2(2 * SEARCH_REACH + 2) + 1;
   localparam int DB = 2 * CB + 2;
   localparam int MAXC = MAX_CELLS_PER_AXIS;

   // configuration
   logic [MIN_DIST_BITS-1:0] min_dist_ff;
   logic [INV_LEN_BITS-1:0]  inv_len_ff;
   logic [NCELL_BITS-1:0]    ncx_ff, ncy_ff, ncz_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= '0;
         inv_len_ff <= INV_LEN_BITS'(65536);
         ncx_ff <= NCELL_BITS'(32);
         ncy_ff <= NCELL_BITS'(32);
         ncz_ff <= NCELL_BITS'(32);
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_MIN_DIST_SQ:  min_dist_ff <= csr_data;
            REG_INV_CELL_LEN: inv_len_ff <= csr_data[INV_LEN_BITS-1:0];
            REG_CELLS_X:      ncx_ff <= csr_data[NCELL_BITS-1:0];
            REG_CELLS_Y:      ncy_ff <= csr_data[NCELL_BITS-1:0];
            REG_CELLS_Z:      ncz_ff <= csr_data[NCELL_BITS-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [AXB:0] eff_cells(input logic [NCELL_BITS-1:0] n);
      logic [AXB:0] r;
      if (n == '0) r = (AXB+1)'(1);
      else if (32'(n) > MAXC) r = (AXB+1)'(MAXC);
      else r = (AXB+1)'(n);
      return r;
   endfunction

   // state
   state_type st_ff, st_in;
   logic [CB-1:0] px_ff, py_ff, pz_ff;
   logic [PRODB-1:0] mx_ff, my_ff, mz_ff;
   logic [AXB:0] nx_ff, ny_ff, nz_ff;
   logic [AXB-1:0] ix_ff, iy_ff, iz_ff;
   logic [AB-1:0] cell_ff, cell_in;
   logic [2*AXB+1:0] nxy_ff;
   logic [OFFB-1:0] oa_ff, ob_ff, oc_ff;
   logic [AB-1:0] clr_ff;
   logic [CNTB-1:0] total_ff;
   logic [VERDICT_BITS-1:0] verd_ff;
   logic [DB-1:0] dx_ff, dy_ff, dz_ff;
   logic [DB+1:0] dsum;
   logic [AB:0] q_ff;
   logic q_ok_ff;

   // memories
   logic used_we, used_wd, used_rd;
   logic [AB-1:0] used_wa, mem_ra;
   logic own_we;
   logic [AB-1:0] own_rd;
   logic pt_we;
   logic [AB-1:0] pt_ra;
   logic [3*CB-1:0] pt_rd;

   mdpg_ram #(.WIDTH(1), .DEPTH(CAP)) u_used (
      .clock(clock), .wr_en(used_we), .wr_addr(used_wa), .wr_data(used_wd),
      .rd_addr(mem_ra), .rd_data(used_rd));
   mdpg_ram #(.WIDTH(AB), .DEPTH(CAP)) u_owner (
      .clock(clock), .wr_en(own_we), .wr_addr(cell_ff), .wr_data(total_ff[AB-1:0]),
      .rd_addr(mem_ra), .rd_data(own_rd));
   mdpg_ram #(.WIDTH(3*CB), .DEPTH(CAP)) u_point (
      .clock(clock), .wr_en(pt_we), .wr_addr(total_ff[AB-1:0]),
      .wr_data({px_ff, py_ff, pz_ff}), .rd_addr(pt_ra), .rd_data(pt_rd));

   // neighbour coordinates
   logic signed [AXB+OFFB:0] na, nb, nc;
   logic a_ok, b_ok, c_ok;
   assign na = $signed({1'b0, ix_ff}) + $signed({1'b0, oa_ff})
             - (AXB+OFFB+1)'(SEARCH_REACH);
   assign nb = $signed({1'b0, iy_ff}) + $signed({1'b0, ob_ff})
             - (AXB+OFFB+1)'(SEARCH_REACH);
   assign nc = $signed({1'b0, iz_ff}) + $signed({1'b0, oc_ff})
             - (AXB+OFFB+1)'(SEARCH_REACH);
   assign a_ok = (na >= 0) && (na < $signed({1'b0, nx_ff}));
   assign b_ok = (nb >= 0) && (nb < $signed({1'b0, ny_ff}));
   assign c_ok = (nc >= 0) && (nc < $signed({1'b0, nz_ff}));
   localparam logic [OFFB-1:0] OFF_LAST = OFFB'(2 * SEARCH_REACH);
   localparam logic [OFFB-1:0] OFF_END = OFFB'(2 * SEARCH_REACH + 1);

   // every offset has been presented once oa_ff steps past the last one
   logic scan_done;
   assign scan_done = (oa_ff == OFF_END);

   // linear index of the scanned neighbour, one multiply for each of the y and z terms
   logic [3*AXB+3:0] q_full;
   assign q_full = (3*AXB+4)'(na[AXB:0]) + (3*AXB+4)'(nb[AXB:0]) * (3*AXB+4)'(nx_ff)
                 + (3*AXB+4)'(nc[AXB:0]) * (3*AXB+4)'(nxy_ff);

   logic in_x, in_y, in_z;
   assign in_x = (mx_ff[PRODB-1:16] < (PRODB-16)'(nx_ff));
   assign in_y = (my_ff[PRODB-1:16] < (PRODB-16)'(ny_ff));
   assign in_z = (mz_ff[PRODB-1:16] < (PRODB-16)'(nz_ff));

   logic [3*AXB+3:0] cell_full;
   assign cell_full = (3*AXB+4)'(ix_ff) + (3*AXB+4)'(iy_ff) * (3*AXB+4)'(nx_ff)
                    + (3*AXB+4)'(iz_ff) * (3*AXB+4)'(nxy_ff);

   logic cell_big;
   assign cell_big = (cell_full >= (3*AXB+4)'(CAP));

   // point distance
   logic [CB-1:0] sx, sy, sz;
   assign {sx, sy, sz} = pt_rd;

   function automatic logic [DB-1:0] sqd(input logic [CB-1:0] a, input logic [CB-1:0] b);
      logic [CB-1:0] d;
      d = (a >= b) ? a - b : b - a;
      return DB'(d) * DB'(d);
   endfunction

   assign dsum = (DB+2)'(dx_ff) + (DB+2)'(dy_ff) + (DB+2)'(dz_ff);

   logic accept, rsp_take;
   assign accept = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // hit: the neighbour read presented last cycle holds a stored point
   logic hit, close, present;
   assign hit = q_ok_ff && used_rd;
   assign close = (dsum < (DB+2)'(min_dist_ff));
   assign present = (st_ff == ST_SCAN)
                 || (st_ff == ST_OWNER && !hit && !scan_done)
                 || (st_ff == ST_SUM && !close && !scan_done);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_CLEAR: if (clr_ff == AB'(CAP - 1)) st_in = ST_IDLE;
         ST_IDLE:  if (accept) st_in = ST_MUL;
         ST_MUL:   st_in = ST_CELL;
         ST_CELL:  st_in = (in_x && in_y && in_z) ? ST_CHECK : ST_DONE;
         ST_CHECK: st_in = ST_SCAN;
         ST_SCAN: begin
            if (cell_big || used_rd) st_in = ST_DONE;
            else st_in = ST_OWNER;
         end
         ST_OWNER: begin
            if (hit) st_in = ST_POINT;
            else if (scan_done) st_in = ST_WRITE;
            else st_in = ST_OWNER;
         end
         ST_POINT: st_in = ST_DIST;
         ST_DIST:  st_in = ST_SUM;
         ST_SUM: begin
            if (close) st_in = ST_DONE;
            else if (scan_done) st_in = ST_WRITE;
            else st_in = ST_OWNER;
         end
         ST_WRITE: st_in = ST_DONE;
         ST_DONE:  if (rsp_take) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (st_ff != ST_IDLE);
      rsp_valid = (st_ff == ST_DONE);
      used_we = 1'b0;
      used_wa = cell_ff;
      used_wd = 1'b1;
      own_we = 1'b0;
      pt_we = 1'b0;
      mem_ra = cell_in;
      pt_ra = own_rd;
      case (st_ff)
         ST_CLEAR: begin
            used_we = 1'b1;
            used_wa = clr_ff;
            used_wd = 1'b0;
         end
         ST_SCAN:  mem_ra = q_full[AB-1:0];
         // on a hit, hold the address so the owner read feeds the point read
         ST_OWNER: mem_ra = hit ? q_ff[AB-1:0] : q_full[AB-1:0];
         ST_SUM:   mem_ra = q_full[AB-1:0];
         ST_WRITE: begin
            used_we = (total_ff < CNTB'(CAP));
            own_we = used_we;
            pt_we = used_we;
         end
         default: ;
      endcase
   end

   assign cell_in = cell_full[AB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         total_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_CLEAR) clr_ff <= clr_ff + AB'(1);
         if (st_ff == ST_WRITE && total_ff < CNTB'(CAP)) total_ff <= total_ff + CNTB'(1);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            px_ff <= req_cand_x[CB-1:0];
            py_ff <= req_cand_y[CB-1:0];
            pz_ff <= req_cand_z[CB-1:0];
            nx_ff <= eff_cells(ncx_ff);
            ny_ff <= eff_cells(ncy_ff);
            nz_ff <= eff_cells(ncz_ff);
         end
         ST_MUL: begin
            mx_ff <= PRODB'(px_ff) * PRODB'(inv_len_ff);
            my_ff <= PRODB'(py_ff) * PRODB'(inv_len_ff);
            mz_ff <= PRODB'(pz_ff) * PRODB'(inv_len_ff);
            nxy_ff <= (2*AXB+2)'(nx_ff) * (2*AXB+2)'(ny_ff);
         end
         ST_CELL: begin
            ix_ff <= mx_ff[16 +: AXB];
            iy_ff <= my_ff[16 +: AXB];
            iz_ff <= mz_ff[16 +: AXB];
            verd_ff <= (in_x && in_y && in_z) ? VERDICT_ACCEPT : VERDICT_OUTSIDE;
            cell_ff <= '0;
         end
         ST_CHECK: begin
            cell_ff <= cell_in;
            oa_ff <= '0;
            ob_ff <= '0;
            oc_ff <= '0;
         end
         ST_SCAN: begin
            if (cell_big || used_rd) verd_ff <= VERDICT_OCCUPIED;
         end
         default: ;
      endcase
      // present the current offset and advance; the answer is checked next cycle
      if (present) begin
         q_ff <= (AB+1)'(q_full);
         q_ok_ff <= a_ok && b_ok && c_ok && (q_full < (3*AXB+4)'(CAP));
         if (oc_ff != OFF_LAST) oc_ff <= oc_ff + OFFB'(1);
         else begin
            oc_ff <= '0;
            if (ob_ff != OFF_LAST) ob_ff <= ob_ff + OFFB'(1);
            else begin
               ob_ff <= '0;
               oa_ff <= oa_ff + OFFB'(1);
            end
         end
      end
      if (st_ff == ST_DIST) begin
         dx_ff <= sqd(sx, px_ff);
         dy_ff <= sqd(sy, py_ff);
         dz_ff <= sqd(sz, pz_ff);
      end
      if (st_ff == ST_SUM && close) verd_ff <= VERDICT_CLOSE;
      if (st_ff == ST_WRITE) begin
         rsp_point_index <= (total_ff < CNTB'(CAP)) ? CELL_OUT_BITS'(total_ff) : '0;
      end
      if (st_ff == ST_CELL || st_ff == ST_CHECK) rsp_point_index <= '0;
   end

   assign rsp_verdict = verd_ff;
   assign rsp_cell_index = CELL_OUT_BITS'(cell_ff);
   assign rsp_point_count = COUNT_OUT_BITS'(total_ff);
endmodule

>>> dv/testbench.sv
// Self-checking testbench for the minimum-distance point grid insert core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mdpg_pkg::*;

   localparam int GRID_CAP = 32768;
   localparam int AXIS_MAX = 32;
   localparam int REACH = 2;
   localparam int IDLE_LIMIT = 200000;
   localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd5;

   typedef struct {
      verdict_type verdict;
      logic [14:0] cell_index;
      logic [14:0] point_index;
      logic [15:0] point_count;
   } insert_result_type;

   class insert_scoreboard;
      logic [33:0] min_dist_sq = 0;
      logic [31:0] inv_cell_len = 32'd65536;
      logic [5:0]  cells_x = 6'd32, cells_y = 6'd32, cells_z = 6'd32;
      bit          cell_taken[GRID_CAP];
      logic [15:0] cell_point[GRID_CAP];
      logic [15:0] pt_x[GRID_CAP], pt_y[GRID_CAP], pt_z[GRID_CAP];
      int          point_total = 0;
      insert_result_type pending[$];
      int          errors = 0;

      function void write_reg(logic [2:0] idx, logic [33:0] val);
         case (idx)
            REG_MIN_DIST_SQ:  min_dist_sq = val;
            REG_INV_CELL_LEN: inv_cell_len = val[31:0];
            REG_CELLS_X:      cells_x = val[5:0];
            REG_CELLS_Y:      cells_y = val[5:0];
            REG_CELLS_Z:      cells_z = val[5:0];
            default: ;
         endcase
      endfunction

      function int axis_cells(logic [5:0] n);
         if (n == 0) return 1;
         if (n > AXIS_MAX) return AXIS_MAX;
         return int'(n);
      endfunction

      function longint sq(logic [15:0] a, logic [15:0] b);
         longint d;
         d = (a >= b) ? longint'(a - b) : longint'(b - a);
         return d * d;
      endfunction

      // predict the insert outcome and update the grid copy
      function void note_candidate(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
         insert_result_type r;
         int nx, ny, nz, cell_id, q, o;
         longint cx, cy, cz;
         int ix, iy, iz, a, b, c;
         nx = axis_cells(cells_x);
         ny = axis_cells(cells_y);
         nz = axis_cells(cells_z);
         cx = (longint'(px) * longint'(inv_cell_len)) >>> 16;
         cy = (longint'(py) * longint'(inv_cell_len)) >>> 16;
         cz = (longint'(pz) * longint'(inv_cell_len)) >>> 16;
         r.verdict = VERDICT_ACCEPT;
         r.cell_index = 0;
         r.point_index = 0;
         if (cx >= nx || cy >= ny || cz >= nz) begin
            r.verdict = VERDICT_OUTSIDE;
         end else begin
            ix = int'(cx); iy = int'(cy); iz = int'(cz);
            cell_id = ix + iy * nx + iz * nx * ny;
            r.cell_index = cell_id[14:0];
            if (cell_id >= GRID_CAP || cell_taken[cell_id]) begin
               r.verdict = VERDICT_OCCUPIED;
            end else begin
               for (a = (ix >= REACH ? ix - REACH : 0); a <= ix + REACH && a < nx; a++)
                  for (b = (iy >= REACH ? iy - REACH : 0); b <= iy + REACH && b < ny; b++)
                     for (c = (iz >= REACH ? iz - REACH : 0); c <= iz + REACH && c < nz;
                          c++) begin
                        q = a + b * nx + c * nx * ny;
                        if (q < GRID_CAP && cell_taken[q]) begin
                           o = int'(cell_point[q]);
                           if (sq(pt_x[o], px) + sq(pt_y[o], py) + sq(pt_z[o], pz)
                               < longint'(min_dist_sq))
                              r.verdict = VERDICT_CLOSE;
                        end
                     end
               if (r.verdict == VERDICT_ACCEPT && point_total < GRID_CAP) begin
                  r.point_index = point_total[14:0];
                  pt_x[point_total] = px;
                  pt_y[point_total] = py;
                  pt_z[point_total] = pz;
                  cell_point[cell_id] = point_total[15:0];
                  cell_taken[cell_id] = 1;
                  point_total++;
               end
            end
         end
         r.point_count = point_total[15:0];
         pending.push_back(r);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [1:0] v, logic [14:0] ci, logic [14:0] pi, logic [15:0] pc);
         insert_result_type e;
         if (pending.size() == 0) begin
            report("result transaction with no candidate outstanding");
         end else begin
            e = pending.pop_front();
            if (v !== e.verdict)
               report($sformatf("verdict %0d, want %0d", v, e.verdict));
            if (ci !== e.cell_index)
               report($sformatf("cell_index %0d, want %0d", ci, e.cell_index));
            if (pi !== e.point_index)
               report($sformatf("point_index %0d, want %0d", pi, e.point_index));
            if (pc !== e.point_count)
               report($sformatf("point_count %0d, want %0d", pc, e.point_count));
         end
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_stall;
   logic [15:0] req_cand_x, req_cand_y, req_cand_z;
   logic rsp_valid, rsp_stall;
   logic [VERDICT_BITS-1:0] rsp_verdict;
   logic [CELL_OUT_BITS-1:0] rsp_cell_index, rsp_point_index;
   logic [COUNT_OUT_BITS-1:0] rsp_point_count;
   logic csr_valid, csr_ready;
   logic [CFG_INDEX_BITS-1:0] csr_index;
   logic [CFG_DATA_BITS-1:0] csr_data;

   insert_scoreboard grid_sb = new();
   bit steady;       // phase without idling
   int idle_cycles = 0;

   min_distance_point_grid_insert_core uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall)
            grid_sb.note_candidate(req_cand_x, req_cand_y, req_cand_z);
         if (rsp_valid && !rsp_stall)
            grid_sb.check_result(rsp_verdict, rsp_cell_index, rsp_point_index, rsp_point_count);
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // receiver back-pressure
   initial begin
      int g;
      rsp_stall = 1;
      @(negedge clock);
      forever begin
         g = pick_gap();
         if (g > 0) begin
            rsp_stall = 1;
            repeat (g) @(negedge clock);
         end
         rsp_stall = 0;
         @(negedge clock);
      end
   end

   task write_csr(logic [2:0] idx, logic [33:0] val);
      csr_valid = 1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      grid_sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task send_candidate(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      int g;
      req_valid = 1;
      req_cand_x = x;
      req_cand_y = y;
      req_cand_z = z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      g = pick_gap();
      if (g > 0) begin
         req_valid = 0;
         req_cand_x = 16'($urandom);
         repeat (g) @(negedge clock);
      end
   endtask

   // hold until every result is back, then let the core settle
   task drain();
      @(negedge clock);
      req_valid = 0;
      while (grid_sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task random_phase(int count);
      logic [31:0] inv;
      longint reach_x, reach_y, reach_z, d;
      int k, sel;
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
         0: inv = 32;
         1: inv = 64;
         2: inv = $urandom_range(16, 512);
         default: inv = $urandom_range(512, 8192);
      endcase
      write_csr(REG_INV_CELL_LEN, 34'(inv));
      write_csr(REG_CELLS_X, 34'($urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : 32));
      write_csr(REG_CELLS_Y, 34'($urandom_range(0, 4) == 0 ? $urandom_range(0, 63) : 32));
      write_csr(REG_CELLS_Z, 34'($urandom_range(0, 4) == 0 ? $urandom_range(0, 63) : 32));
      // minimum distance around one cell edge so both verdicts show up
      d = (longint'($urandom_range(30, 250)) * 65536 / inv) / 100;
      write_csr(REG_MIN_DIST_SQ, 34'(d * d));
      reach_x = longint'(grid_sb.axis_cells(grid_sb.cells_x)) * 65536 / inv;
      reach_y = longint'(grid_sb.axis_cells(grid_sb.cells_y)) * 65536 / inv;
      reach_z = longint'(grid_sb.axis_cells(grid_sb.cells_z)) * 65536 / inv;
      if (reach_x > 65535) reach_x = 65535;
      if (reach_y > 65535) reach_y = 65535;
      if (reach_z > 65535) reach_z = 65535;
      @(negedge clock);
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(0, 9);
         if (sel == 0)
            send_candidate(16'($urandom), 16'($urandom), 16'($urandom));
         else
            send_candidate(16'($urandom_range(0, 32'(reach_x))),
                           16'($urandom_range(0, 32'(reach_y))),
                           16'($urandom_range(0, 32'(reach_z))));
      end
      drain();
   endtask

   initial begin
      req_valid = 0;
      req_cand_x = 0;
      req_cand_y = 0;
      req_cand_z = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      steady = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset geometry: unit cells, no distance limit
      send_candidate(0, 0, 0);
      send_candidate(0, 0, 0);
      send_candidate(1, 0, 0);
      send_candidate(31, 31, 31);
      send_candidate(32, 0, 0);
      send_candidate(0, 0, 32);
      send_candidate(16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain();

      // extremes: widest distance, largest scale, clamped cell counts
      write_csr(REG_MIN_DIST_SQ, 34'h3_FFFF_FFFF);
      write_csr(REG_INV_CELL_LEN, 34'h0_FFFF_FFFF);
      write_csr(REG_CELLS_X, 34'd0);
      write_csr(REG_CELLS_Y, 34'd63);
      write_csr(REG_CELLS_Z, 34'd63);
      write_csr(REG_UNMAPPED, 34'h3_FFFF_FFFF);
      @(negedge clock);
      send_candidate(0, 0, 0);
      send_candidate(0, 1, 0);
      send_candidate(1, 0, 0);
      send_candidate(0, 0, 16'h8000);
      drain();

      // zero scale folds everything into cell zero; fine scale with huge distance
      write_csr(REG_INV_CELL_LEN, 34'd0);
      write_csr(REG_CELLS_X, 34'd32);
      @(negedge clock);
      send_candidate(16'hFFFF, 16'h5555, 16'hAAAA);
      drain();
      write_csr(REG_INV_CELL_LEN, 34'd32);
      @(negedge clock);
      send_candidate(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_candidate(16'hF000, 16'hF000, 16'hF000);
      send_candidate(16'h8000, 16'h8000, 16'h8000);
      drain();
      write_csr(REG_MIN_DIST_SQ, 34'd0);
      @(negedge clock);
      send_candidate(16'hF800, 16'hFFFF, 16'hFFFF);
      send_candidate(16'h5555, 16'hAAAA, 16'h5555);
      drain();

      repeat (6) random_phase(250);

      repeat (2000) @(negedge clock);
      if (grid_sb.errors == 0 && grid_sb.pending.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
